[rtl/assert_macros.svh]
// Assertion helpers. Each expects clk and rst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

`define ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/elom_pkg.sv]
package elom_pkg;

    localparam int LOG_DEPTH     = 64;
    localparam int OFFSET_BITS   = 24;
    localparam int IDX_BITS      = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int CNT_BITS      = $clog2(LOG_DEPTH + 1);
    localparam int ARITH_BITS    = OFFSET_BITS + 3;
    localparam int OP_BITS       = 2;
    localparam int IN_FIELD_BITS = 3 * OFFSET_BITS;
    localparam int IN_DATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = OFFSET_BITS + 2 + CNT_BITS;
    localparam int OUT_DATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

    localparam logic [ARITH_BITS-1:0] OFF_MAX =
        ARITH_BITS'({OFFSET_BITS{1'b1}});

    typedef enum logic [OP_BITS-1:0] {
        OP_ADD   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_FWD   = 2'd2,
        OP_BACK  = 2'd3
    } op_t;

    typedef struct packed {
        logic [OFFSET_BITS-1:0] inserted;
        logic [OFFSET_BITS-1:0] removed;
        logic [OFFSET_BITS-1:0] start;
    } entry_t;

    typedef struct packed {
        logic load;
        logic issue;
        logic step;
        logic add_cmp;
        logic add_wr;
        logic clear;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic count_zero;
        logic last_issue;
        logic out_free;
    } status_t;

    function automatic logic [OFFSET_BITS-1:0] sat_off(input logic [ARITH_BITS-1:0] v);
        logic [ARITH_BITS-1:0] s;
        s = (v > OFF_MAX) ? OFF_MAX : v;
        return s[OFFSET_BITS-1:0];
    endfunction

endpackage

[rtl/elom_ram.sv]
module elom_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/elom_ctrl.sv]
`include "assert_macros.svh"

module elom_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [elom_pkg::OP_BITS-1:0]  s_tuser,
    input  elom_pkg::status_t             status,
    output elom_pkg::cmd_t                cmd
);
    import elom_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_CLR     = 8'b0000_0010,
        S_ADD_RD  = 8'b0000_0100,
        S_ADD_CMP = 8'b0000_1000,
        S_ADD_WR  = 8'b0001_0000,
        S_WALK    = 8'b0010_0000,
        S_DRAIN   = 8'b0100_0000,
        S_DONE    = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   walk_data_reg, walk_data_next;
    logic   accept;
    op_t    in_op;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign in_op    = op_t'(s_tuser);

    always_comb
    begin
        state_next     = state_reg;
        walk_data_next = 1'b0;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load = 1'b1;
                    case (in_op)
                        OP_ADD:   state_next = S_ADD_RD;
                        OP_CLEAR: state_next = S_CLR;
                        default:  state_next = status.count_zero ? S_DONE : S_WALK;
                    endcase
                end
            end
            S_CLR:
            begin
                cmd.clear  = 1'b1;
                state_next = S_DONE;
            end
            S_ADD_RD:
            begin
                cmd.issue  = 1'b1;
                state_next = S_ADD_CMP;
            end
            S_ADD_CMP:
            begin
                cmd.add_cmp = 1'b1;
                state_next  = S_ADD_WR;
            end
            S_ADD_WR:
            begin
                cmd.add_wr = 1'b1;
                state_next = S_DONE;
            end
            S_WALK:
            begin
                cmd.issue      = 1'b1;
                cmd.step       = walk_data_reg;
                walk_data_next = 1'b1;
                if (status.last_issue)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                cmd.step   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            walk_data_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            walk_data_reg <= walk_data_next;
        end
    end

    `ASSERT_IMPLIES(a_finish_needs_room, cmd.finish, status.out_free)
    `ASSERT_NEXT(a_walk_ends_in_drain, state_reg == S_WALK && status.last_issue, state_reg == S_DRAIN)

endmodule

[rtl/elom_datapath.sv]
`include "assert_macros.svh"

module elom_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [elom_pkg::IN_DATA_BITS-1:0]   s_tdata,
    input  logic [elom_pkg::OP_BITS-1:0]        s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [elom_pkg::OUT_DATA_BITS-1:0]  m_tdata,
    input  elom_pkg::cmd_t                      cmd,
    output elom_pkg::status_t                   status
);
    import elom_pkg::*;

    logic [CNT_BITS-1:0]    count_reg, count_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_BITS-1:0] m_data_reg;
    op_t                    op_reg;
    logic [OFFSET_BITS-1:0] off_reg, off_next;
    logic [OFFSET_BITS-1:0] rem_reg;
    logic [OFFSET_BITS-1:0] ins_reg;
    logic [IDX_BITS-1:0]    addr_reg;
    logic [CNT_BITS-1:0]    steps_reg;
    logic [ARITH_BITS-1:0]  pre_reg, post_reg;
    logic                   touch_reg;
    logic                   merged_reg, full_reg;

    logic [CNT_BITS-1:0]    cnt_m1;
    logic                   count_full;
    logic                   fwd;
    op_t                    in_op;
    logic [IDX_BITS-1:0]    addr_init;

    logic                   wr_en;
    logic [IDX_BITS-1:0]    wr_addr;
    entry_t                 wr_entry;
    logic [$bits(entry_t)-1:0] rd_word;
    entry_t                 ent;

    logic [ARITH_BITS-1:0]  cur, eo, ei, er, sub_amt, add_amt;
    logic [ARITH_BITS-1:0]  p, r, i;
    logic [ARITH_BITS-1:0]  end_new, end_old, pre_c, post_c;
    logic                   touch_c;
    logic [ARITH_BITS-1:0]  ni, nr, ns;
    logic [OFFSET_BITS-1:0] step_off;
    logic [OFFSET_BITS-1:0] mapped;

    assign cnt_m1     = count_reg - 1'b1;
    assign count_full = (count_reg == CNT_BITS'(LOG_DEPTH));
    assign fwd        = (op_reg == OP_FWD);
    assign in_op      = op_t'(s_tuser);
    assign addr_init  = (in_op == OP_FWD) ? '0 : cnt_m1[IDX_BITS-1:0];

    assign ent = entry_t'(rd_word);

    elom_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (LOG_DEPTH)
    ) u_log_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (cmd.issue),
        .rd_addr (addr_reg),
        .rd_data (rd_word)
    );

    // one map step against the entry just read
    always_comb
    begin
        cur     = ARITH_BITS'(off_reg);
        eo      = ARITH_BITS'(ent.start);
        er      = ARITH_BITS'(ent.removed);
        ei      = ARITH_BITS'(ent.inserted);
        sub_amt = fwd ? er : ei;
        add_amt = fwd ? ei : er;
        step_off = off_reg;
        if (cur >= eo)
        begin
            if (cur < eo + sub_amt)
            begin
                step_off = ent.start;
            end
            else
            begin
                step_off = sat_off(cur - sub_amt + add_amt);
            end
        end
    end

    // merge test against the newest entry
    always_comb
    begin
        p       = ARITH_BITS'(off_reg);
        r       = ARITH_BITS'(rem_reg);
        i       = ARITH_BITS'(ins_reg);
        end_new = p + r;
        end_old = eo + ei;
        touch_c = !status.count_zero && (end_new >= eo) && (p <= end_old);
        pre_c   = (eo > p) ? eo - p : '0;
        post_c  = (end_new > end_old) ? end_new - end_old : '0;
    end

    always_comb
    begin
        ni = ei + i + pre_reg + post_reg - r;
        nr = er + pre_reg + post_reg;
        ns = eo - pre_reg;
        wr_en   = cmd.add_wr && (touch_reg || !count_full);
        wr_addr = touch_reg ? cnt_m1[IDX_BITS-1:0] : count_reg[IDX_BITS-1:0];
        if (touch_reg)
        begin
            wr_entry.start    = ns[OFFSET_BITS-1:0];
            wr_entry.removed  = sat_off(nr);
            wr_entry.inserted = sat_off(ni);
        end
        else
        begin
            wr_entry.start    = off_reg;
            wr_entry.removed  = rem_reg;
            wr_entry.inserted = ins_reg;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.clear)
        begin
            count_next = '0;
        end
        else if (cmd.add_wr && !touch_reg && !count_full)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_comb
    begin
        off_next = off_reg;
        if (cmd.load)
        begin
            off_next = s_tdata[OFFSET_BITS-1:0];
        end
        else if (cmd.step)
        begin
            off_next = step_off;
        end
    end

    assign mapped = (op_reg == OP_FWD || op_reg == OP_BACK) ? off_reg : '0;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.finish)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        off_reg <= off_next;
        if (cmd.load)
        begin
            op_reg     <= in_op;
            rem_reg    <= s_tdata[2*OFFSET_BITS-1:OFFSET_BITS];
            ins_reg    <= s_tdata[3*OFFSET_BITS-1:2*OFFSET_BITS];
            addr_reg   <= addr_init;
            steps_reg  <= count_reg;
            merged_reg <= 1'b0;
            full_reg   <= 1'b0;
        end
        if (cmd.issue)
        begin
            addr_reg  <= fwd ? addr_reg + 1'b1 : addr_reg - 1'b1;
            steps_reg <= steps_reg - 1'b1;
        end
        if (cmd.add_cmp)
        begin
            pre_reg   <= pre_c;
            post_reg  <= post_c;
            touch_reg <= touch_c;
        end
        if (cmd.add_wr)
        begin
            merged_reg <= touch_reg;
            full_reg   <= !touch_reg && count_full;
        end
        if (cmd.finish)
        begin
            m_data_reg <= OUT_DATA_BITS'({count_reg, full_reg, merged_reg, mapped});
        end
    end

    assign status.count_zero = (count_reg == '0);
    assign status.last_issue = (steps_reg == CNT_BITS'(1));
    assign status.out_free   = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

    `ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_BITS'(LOG_DEPTH))
    `ASSERT_NEXT(a_merge_keeps_count, cmd.add_wr && touch_reg, count_reg == $past(count_reg))
    `ASSERT_IMPLIES(a_flags_exclusive, m_tvalid_reg, !(merged_reg && full_reg))

endmodule

[rtl/edit_log_offset_mapper_unit.sv]
// Channel   Dir   Signals                      Word
// s_*       in    s_tvalid s_tready s_tdata    tdata: position, removed_count, inserted_count
//                 s_tuser                      tuser: opcode
// m_*       out   m_tvalid m_tready m_tdata    tdata: mapped_position, was_merged,
//                                              log_full, entries_used
//
// Map words make one RAM read per log entry, and none on an empty log.
// Add reads the newest entry, compares and writes; clear empties the log.
// One word is processed at a time; the next is taken once the result sits in the
// output register, which holds it while m_tready is low.
// rst_n is asynchronous and empties the log; entry storage is not cleared.
module edit_log_offset_mapper_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [23:0] position, [47:24] removed_count, [71:48] inserted_count
    input  logic [elom_pkg::IN_DATA_BITS-1:0]   s_tdata,
    // [1:0] opcode
    input  logic [elom_pkg::OP_BITS-1:0]        s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [23:0] mapped_position, [24] was_merged, [25] log_full, [32:26] entries_used
    output logic [elom_pkg::OUT_DATA_BITS-1:0]  m_tdata
);
    import elom_pkg::*;

    cmd_t    cmd;
    status_t status;

    elom_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    elom_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .status   (status)
    );

endmodule
